// File: design/assert_macros.svh
// Assertion macros for the tick task scheduler table.
// Used by the top level only; compiles to nothing when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is low
`define TTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also runs through reset
`define TTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TTS_ASSERT(lbl, clk, rstn, prop, msg)
`define TTS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: design/tts_pkg.sv
// Shared types and constants of the tick task scheduler table.
// No dependencies; imported by every module of the block except tts_ram.
`default_nettype none

package tts_pkg;

    // Table size and slot index width
    localparam int MAX_TASKS = 8;
    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_slot LAST_SLOT = t_slot'(MAX_TASKS - 1);

    // Item modes
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_DEL  = 2'd2;
    localparam logic [1:0] MODE_DISP = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_DUE  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_NONE = 2'd3;

    localparam logic [7:0] PEND_MAX = 8'hFF;

    // One task entry as held in the table memory
    typedef struct packed {
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  pend;
    } t_entry;

    // Result of updating one entry during a sweep
    typedef struct packed {
        t_entry entry;
        logic   keep_used;
        logic   due;
    } t_upd;

    // Sweep states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } t_state;

endpackage

`default_nettype wire

// File: design/tick_task_scheduler_table.sv
// Tick task scheduler table. An add or delete item, and a dispatch item with no runs
// pending in any slot, leaves busy low, so the next item may follow in the next cycle.
// A tick item, or a dispatch item with runs pending, sweeps the table memory one slot
// per cycle through a read-modify-write pipeline and holds busy high until the entry
// read last from the registered read port of the entry memory has been modified and
// written back. Results are registered from the step that makes them, each shown for
// exactly one cycle with o_valid high; the receiver cannot stall. A dispatch gives one
// result per slot with runs pending, lowest first, the final one with o_last_result set.
`default_nettype none

`include "assert_macros.svh"

module tick_task_scheduler_table
    import tts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_start_delay,
    input  wire logic [15:0] i_repeat_period,
    input  wire logic [2:0]  i_slot_index,
    output logic             o_valid,
    output logic [2:0]       o_slot_out,
    output logic [1:0]       o_status,
    output logic             o_last_result
);

    t_state               r_state, n_state;
    t_slot                r_cnt, n_cnt;
    logic                 r_mode_tick, n_mode_tick;
    logic                 r_rd_vld, n_rd_vld;
    t_slot                r_rd_slot, n_rd_slot;
    logic [MAX_TASKS-1:0] r_used, n_used;
    logic [MAX_TASKS-1:0] r_due, n_due;

    logic                 r_out_valid, n_out_valid;
    logic [2:0]           r_out_slot, n_out_slot;
    logic [1:0]           r_out_status, n_out_status;
    logic                 r_out_last, n_out_last;

    logic                 w_accept;
    logic                 w_add_wr;
    logic                 w_we;
    t_slot                w_wr_addr;
    t_entry               w_wr_data;
    logic                 w_rd_en;
    t_entry               w_rd_data;
    logic                 w_free_found;
    t_slot                w_free_slot;
    t_upd                 w_upd;
    logic                 w_more_due;
    logic [16:0]          w_delay_sum;
    t_entry               w_new_entry;
    t_slot                w_del_slot;
    logic                 w_del_ok;

    assign busy     = (r_state != ST_IDLE) || r_rd_vld;
    assign w_accept = start && !busy;
    assign w_add_wr = w_accept && (i_mode == MODE_ADD);
    assign w_rd_en  = (r_state == ST_SWEEP);

    tts_ram #(
        .DEPTH (MAX_TASKS),
        .WIDTH ($bits(t_entry)),
        .AW    (SLOT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_cnt),
        .o_rd_data (w_rd_data)
    );

    tts_free_find u_free (
        .i_used  (r_used),
        .o_found (w_free_found),
        .o_slot  (w_free_slot)
    );

    tts_entry_upd u_upd (
        .i_tick  (r_mode_tick),
        .i_entry (w_rd_data),
        .o_upd   (w_upd)
    );

    // Build the entry of a new task
    assign w_delay_sum        = {1'b0, i_start_delay} + 17'd1;
    assign w_new_entry.delay  = w_delay_sum[16] ? 16'hFFFF : w_delay_sum[15:0];
    assign w_new_entry.period = i_repeat_period;
    assign w_new_entry.pend   = 8'd0;

    assign w_del_slot = t_slot'(i_slot_index);
    assign w_del_ok   = (32'(i_slot_index) < 32'(MAX_TASKS));

    // Look for runs pending above the slot in the modify stage
    always_comb begin
        w_more_due = 1'b0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if ((SLOT_W'(i) > r_rd_slot) && r_due[i]) begin
                w_more_due = 1'b1;
            end
        end
    end

    // Control, write-back and result selection
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_mode_tick  = r_mode_tick;
        n_used       = r_used;
        n_due        = r_due;
        n_rd_vld     = (r_state == ST_SWEEP);
        n_rd_slot    = r_cnt;
        w_we         = 1'b0;
        w_wr_addr    = r_rd_slot;
        w_wr_data    = w_upd.entry;
        n_out_valid  = 1'b0;
        n_out_slot   = 3'd0;
        n_out_status = STAT_DONE;
        n_out_last   = 1'b1;

        // Take a new item
        if (w_accept) begin
            case (i_mode)
                MODE_TICK: begin
                    n_state     = ST_SWEEP;
                    n_cnt       = '0;
                    n_mode_tick = 1'b1;
                end
                MODE_DISP: begin
                    if (r_due == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_status = STAT_NONE;
                    end else begin
                        n_state     = ST_SWEEP;
                        n_cnt       = '0;
                        n_mode_tick = 1'b0;
                    end
                end
                MODE_ADD: begin
                    n_out_valid = 1'b1;
                    if (w_free_found) begin
                        w_we                = 1'b1;
                        w_wr_addr           = w_free_slot;
                        w_wr_data           = w_new_entry;
                        n_used[w_free_slot] = 1'b1;
                        n_due[w_free_slot]  = 1'b0;
                        n_out_slot          = 3'(w_free_slot);
                    end else begin
                        n_out_status = STAT_FULL;
                    end
                end
                MODE_DEL: begin
                    n_out_valid = 1'b1;
                    n_out_slot  = i_slot_index;
                    if (w_del_ok) begin
                        n_used[w_del_slot] = 1'b0;
                        n_due[w_del_slot]  = 1'b0;
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end

        // Advance the read address of the sweep
        if (r_state == ST_SWEEP) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_SLOT) begin
                n_state = ST_IDLE;
            end
        end

        // Modify and write back the entry read last cycle
        if (r_rd_vld) begin
            if (r_mode_tick) begin
                if (r_used[r_rd_slot]) begin
                    w_we             = 1'b1;
                    n_due[r_rd_slot] = w_upd.due;
                end
                if (r_rd_slot == LAST_SLOT) begin
                    n_out_valid = 1'b1;
                end
            end else if (r_due[r_rd_slot]) begin
                w_we              = 1'b1;
                n_used[r_rd_slot] = w_upd.keep_used;
                n_due[r_rd_slot]  = w_upd.due;
                n_out_valid       = 1'b1;
                n_out_slot        = 3'(r_rd_slot);
                n_out_status      = STAT_DUE;
                n_out_last        = !w_more_due;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_mode_tick <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_used      <= '0;
            r_due       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_mode_tick <= n_mode_tick;
            r_rd_vld    <= n_rd_vld;
            r_used      <= n_used;
            r_due       <= n_due;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_slot    <= n_rd_slot;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_slot_out    = r_out_slot;
    assign o_status      = r_out_status;
    assign o_last_result = r_out_last;

    // Checks
    `TTS_ASSERT(a_due_used, i_clk, i_rst_n, (r_due & ~r_used) == '0, "due on free slot")
    `TTS_ASSERT(a_more_busy, i_clk, i_rst_n, o_valid && !o_last_result |-> busy, "more while idle")
    `TTS_ASSERT(a_write_src, i_clk, i_rst_n, w_we |-> (r_rd_vld || w_add_wr), "stray table write")
    `TTS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !busy && !o_valid, "busy after reset")

endmodule

`default_nettype wire

// File: design/tts_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the task entries of the scheduler table.
`default_nettype none

module tts_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 40,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/tts_free_find.sv
// Lowest free slot search over the slot used bits.
// Depends on tts_pkg.
`default_nettype none

module tts_free_find
    import tts_pkg::*;
(
    input  wire logic [MAX_TASKS-1:0] i_used,
    output logic                      o_found,
    output t_slot                     o_slot
);

    // Scan from the top so the lowest free slot wins
    always_comb begin
        o_found = 1'b0;
        o_slot  = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (!i_used[i]) begin
                o_found = 1'b1;
                o_slot  = t_slot'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: design/tts_entry_upd.sv
// Modify stage of the table sweep: applies a tick or a dispatch to one entry.
// Depends on tts_pkg.
`default_nettype none

module tts_entry_upd
    import tts_pkg::*;
(
    input  wire logic   i_tick,
    input  t_entry      i_entry,
    output t_upd        o_upd
);

    logic [15:0] w_dec;
    logic [7:0]  w_pend_inc;
    logic [7:0]  w_pend_dec;
    logic        w_periodic;

    assign w_dec      = i_entry.delay - 16'd1;
    assign w_pend_inc = (i_entry.pend == PEND_MAX) ? PEND_MAX : i_entry.pend + 8'd1;
    assign w_pend_dec = i_entry.pend - 8'd1;
    assign w_periodic = (i_entry.period != 16'd0);

    always_comb begin
        o_upd.entry     = i_entry;
        o_upd.keep_used = 1'b1;
        o_upd.due       = 1'b0;
        if (i_tick) begin
            // Count down; on zero mark a run and reload periodic tasks
            o_upd.entry.delay = w_dec;
            if (w_dec == 16'd0) begin
                o_upd.entry.pend = w_pend_inc;
                if (w_periodic) begin
                    o_upd.entry.delay = i_entry.period;
                end
            end
            o_upd.due = (o_upd.entry.pend != 8'd0);
        end else begin
            // Take one run; drop one-shot tasks
            o_upd.entry.pend = w_pend_dec;
            o_upd.keep_used  = w_periodic;
            o_upd.due        = w_periodic && (w_pend_dec != 8'd0);
        end
    end

endmodule

`default_nettype wire

// File: test/task_table_checker.sv
// Checker for the tick task scheduler table: keeps its own copy of the slot table,
// works out the replies owed for every accepted item and compares them in order.
// Depends on tts_pkg for the table size, mode codes and status codes.
module task_table_checker
    import tts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_start_delay,
    input  wire logic [15:0] i_repeat_period,
    input  wire logic [2:0]  i_slot_index,
    input  wire logic        i_valid,
    input  wire logic [2:0]  i_slot_out,
    input  wire logic [1:0]  i_status,
    input  wire logic        i_last_result,
    output int               o_mismatches,
    output int               o_replies_owed,
    output int               o_ticks,
    output int               o_adds,
    output int               o_deletes,
    output int               o_dispatches,
    output int               o_replies,
    output int               o_due_replies,
    output int               o_full_replies
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [2:0] slot;
        logic [1:0] status;
        logic       last;
    } reply_t;

    // Mirror of the slot table
    logic        used_q   [MAX_TASKS];
    logic [15:0] delay_q  [MAX_TASKS];
    logic [15:0] period_q [MAX_TASKS];
    logic [7:0]  pend_q   [MAX_TASKS];

    // Replies owed by the block, oldest first
    reply_t reply_queue [$];

    task automatic clear_entry(input int s);
        used_q[s]   = 1'b0;
        delay_q[s]  = 16'd0;
        period_q[s] = 16'd0;
        pend_q[s]   = 8'd0;
    endtask

    task automatic owe_reply(input int s, input logic [1:0] st, input logic last);
        reply_t r;
        r.slot   = 3'(s);
        r.status = st;
        r.last   = last;
        reply_queue.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input reply_t want, input reply_t got);
        o_mismatches++;
        if (o_mismatches <= PRINT_CAP) begin
            $display("%0t ns mismatch (%s): expected slot %0d status %0d last %0b, got slot %0d status %0d last %0b",
                     $time, what, want.slot, want.status, want.last,
                     got.slot, got.status, got.last);
        end
    endtask

    // Update the table for one item and queue the replies it causes
    task automatic apply_item(input logic [1:0] mode, input logic [15:0] sd,
                              input logic [15:0] rp, input logic [2:0] idx);
        int          free_slot;
        int          n_due;
        int          k;
        logic [16:0] d;
        free_slot = -1;
        n_due     = 0;
        k         = 0;
        case (mode)
            MODE_TICK: begin
                o_ticks++;
                for (int s = 0; s < MAX_TASKS; s++) begin
                    if (used_q[s]) begin
                        // count down, wrapping from zero
                        delay_q[s] = delay_q[s] - 16'd1;
                        if (delay_q[s] == 16'd0) begin
                            if (pend_q[s] != PEND_MAX) pend_q[s] = pend_q[s] + 8'd1;
                            if (period_q[s] != 16'd0) delay_q[s] = period_q[s];
                        end
                    end
                end
                owe_reply(0, STAT_DONE, 1'b1);
            end
            MODE_ADD: begin
                o_adds++;
                for (int s = 0; s < MAX_TASKS; s++) begin
                    if (free_slot < 0 && !used_q[s]) free_slot = s;
                end
                if (free_slot < 0) begin
                    owe_reply(0, STAT_FULL, 1'b1);
                end else begin
                    // store delay plus one, saturated at the top of the field
                    d = {1'b0, sd} + 17'd1;
                    used_q[free_slot]   = 1'b1;
                    delay_q[free_slot]  = d[16] ? 16'hFFFF : d[15:0];
                    period_q[free_slot] = rp;
                    pend_q[free_slot]   = 8'd0;
                    owe_reply(free_slot, STAT_DONE, 1'b1);
                end
            end
            MODE_DEL: begin
                o_deletes++;
                clear_entry(int'(idx));
                owe_reply(int'(idx), STAT_DONE, 1'b1);
            end
            MODE_DISP: begin
                o_dispatches++;
                for (int s = 0; s < MAX_TASKS; s++) begin
                    if (pend_q[s] != 8'd0) n_due++;
                end
                if (n_due == 0) begin
                    owe_reply(0, STAT_NONE, 1'b1);
                end else begin
                    // report due slots lowest first, freeing one-shot tasks
                    for (int s = 0; s < MAX_TASKS; s++) begin
                        if (pend_q[s] != 8'd0) begin
                            k++;
                            owe_reply(s, STAT_DUE, k == n_due);
                            pend_q[s] = pend_q[s] - 8'd1;
                            if (period_q[s] == 16'd0) clear_entry(s);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Predict on every accepted item, then compare any reply of this cycle
    always @(posedge i_clk) begin : watch_channels
        reply_t got;
        reply_t want;
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_TASKS; s++) clear_entry(s);
            reply_queue.delete();
            o_replies_owed <= 0;
        end else begin
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                apply_item(i_mode, i_start_delay, i_repeat_period, i_slot_index);
            end
            got.slot   = i_slot_out;
            got.status = i_status;
            got.last   = i_last_result;
            if (i_valid === 1'b1) begin
                o_replies++;
                if (got.status === STAT_DUE) o_due_replies++;
                if (got.status === STAT_FULL) o_full_replies++;
                if (reply_queue.size() == 0) begin
                    report_mismatch("reply with none owed", '0, got);
                end else begin
                    want = reply_queue.pop_front();
                    if (got.slot !== want.slot) report_mismatch("slot_out", want, got);
                    if (got.status !== want.status) report_mismatch("status", want, got);
                    if (got.last !== want.last) report_mismatch("last_result", want, got);
                end
            end else if (i_valid !== 1'b0) begin
                report_mismatch("unknown strobe", '0, got);
            end
            o_replies_owed <= reply_queue.size();
        end
    end

endmodule

// File: test/testbench.sv
// Top of the tick task scheduler table testbench: clock, reset and item stimulus.
// Instantiates the block and task_table_checker, which predicts and compares;
// the verdict here comes from its mismatch count and the replies still owed.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 195;
    localparam int NUM_PHASES   = 3;
    localparam int LATENCY      = MAX_TASKS + 4;
    localparam int DRAIN_LIMIT  = 200;
    localparam int LIMIT_CYCLES = 400000;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic        busy;
    logic [1:0]  i_mode          = MODE_TICK;
    logic [15:0] i_start_delay   = 16'd0;
    logic [15:0] i_repeat_period = 16'd0;
    logic [2:0]  i_slot_index    = 3'd0;
    logic        o_valid;
    logic [2:0]  o_slot_out;
    logic [1:0]  o_status;
    logic        o_last_result;

    int mismatches;
    int replies_owed;
    int n_ticks, n_adds, n_deletes, n_dispatches;
    int n_replies, n_due, n_full;

    // Sender idle percentage per random phase
    int idle_pct [NUM_PHASES] = '{0, 64, 10};

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    tick_task_scheduler_table i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_start_delay   (i_start_delay),
        .i_repeat_period (i_repeat_period),
        .i_slot_index    (i_slot_index),
        .o_valid         (o_valid),
        .o_slot_out      (o_slot_out),
        .o_status        (o_status),
        .o_last_result   (o_last_result)
    );

    task_table_checker table_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_mode          (i_mode),
        .i_start_delay   (i_start_delay),
        .i_repeat_period (i_repeat_period),
        .i_slot_index    (i_slot_index),
        .i_valid         (o_valid),
        .i_slot_out      (o_slot_out),
        .i_status        (o_status),
        .i_last_result   (o_last_result),
        .o_mismatches    (mismatches),
        .o_replies_owed  (replies_owed),
        .o_ticks         (n_ticks),
        .o_adds          (n_adds),
        .o_deletes       (n_deletes),
        .o_dispatches    (n_dispatches),
        .o_replies       (n_replies),
        .o_due_replies   (n_due),
        .o_full_replies  (n_full)
    );

    // Present one item and hold it until the block takes it; start stays high
    task automatic send_item(input logic [1:0] mode, input logic [15:0] sd,
                             input logic [15:0] rp, input logic [2:0] idx);
        start           <= 1'b1;
        i_mode          <= mode;
        i_start_delay   <= sd;
        i_repeat_period <= rp;
        i_slot_index    <= idx;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // Drop start for a random gap with the given chance
    task automatic sender_pause(input int pct);
        if ($urandom_range(99, 0) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
        end
    endtask

    // Hold off until every owed reply has come, within a bound
    task automatic wait_drained();
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (replies_owed != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // Random item: mostly small delays and periods so tasks come due often
    task automatic send_random_item();
        logic [1:0]  mode;
        logic [15:0] sd;
        logic [15:0] rp;
        logic [2:0]  idx;
        int          pick;
        pick = $urandom_range(99, 0);
        if (pick < 40) mode = MODE_TICK;
        else if (pick < 65) mode = MODE_ADD;
        else if (pick < 80) mode = MODE_DEL;
        else mode = MODE_DISP;
        sd  = 16'($urandom_range(65534, 0));
        rp  = 16'($urandom);
        idx = 3'($urandom);
        if (mode == MODE_ADD) begin
            if ($urandom_range(9, 0) < 8) sd = 16'($urandom_range(4, 0));
            pick = $urandom_range(9, 0);
            if (pick < 3) rp = 16'd0;
            else if (pick < 8) rp = 16'($urandom_range(5, 1));
        end
        send_item(mode, sd, rp, idx);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: nothing due, tick and delete on free slots
        send_item(MODE_DISP, 16'd0, 16'd0, 3'd0);
        send_item(MODE_TICK, 16'd0, 16'd0, 3'd0);
        send_item(MODE_DEL,  16'd0, 16'd0, 3'd3);
        // Fill every slot with a mix of one-shot, periodic and extreme entries
        send_item(MODE_ADD, 16'd0,     16'd0,     3'd0);
        send_item(MODE_ADD, 16'd0,     16'd1,     3'd0);
        send_item(MODE_ADD, 16'd65534, 16'd65535, 3'd0);
        send_item(MODE_ADD, 16'd1,     16'd0,     3'd0);
        send_item(MODE_ADD, 16'd2,     16'd3,     3'd0);
        send_item(MODE_ADD, 16'd0,     16'd65535, 3'd0);
        send_item(MODE_ADD, 16'd3,     16'd2,     3'd0);
        send_item(MODE_ADD, 16'd0,     16'd0,     3'd0);
        // Table full
        send_item(MODE_ADD, 16'd5, 16'd5, 3'd0);
        // Second tick wraps past zero the one-shot delays that reached zero on the first
        send_item(MODE_TICK, 16'd0, 16'd0, 3'd0);
        send_item(MODE_TICK, 16'd0, 16'd0, 3'd0);
        // Multi-reply dispatch, then leftover runs, then nothing due
        send_item(MODE_DISP, 16'd0, 16'd0, 3'd0);
        send_item(MODE_DISP, 16'd0, 16'd0, 3'd0);
        send_item(MODE_DISP, 16'd0, 16'd0, 3'd0);
        // Delete freed and used slots, then reuse the lowest free one
        send_item(MODE_DEL, 16'd0, 16'd0, 3'd7);
        send_item(MODE_DEL, 16'd0, 16'd0, 3'd2);
        send_item(MODE_ADD, 16'd0, 16'd0, 3'd0);
        send_item(MODE_TICK, 16'd0, 16'd0, 3'd0);
        send_item(MODE_DISP, 16'd0, 16'd0, 3'd0);
        send_item(MODE_DEL, 16'd0, 16'd0, 3'd0);
        wait_drained();

        // Random items under each sender idling phase, draining now and then
        for (int p = 0; p < NUM_PHASES; p++) begin
            for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES + 1; n++) begin
                send_random_item();
                sender_pause(idle_pct[p]);
                if ($urandom_range(39, 0) == 0) wait_drained();
            end
            wait_drained();
        end

        repeat (LATENCY) @(posedge i_clk);

        $display("Covered %0d items: %0d ticks, %0d adds, %0d deletes, %0d dispatches",
                 n_ticks + n_adds + n_deletes + n_dispatches,
                 n_ticks, n_adds, n_deletes, n_dispatches);
        $display("Checked %0d replies: %0d due reports, %0d table-full replies, %0d still owed",
                 n_replies, n_due, n_full, replies_owed);
        if (mismatches == 0 && replies_owed == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Bound the run in case the block hangs
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Regression FAIL");
        $finish;
    end

endmodule
